// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the ALU checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge and off in reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Delayed implication.
`define ASSERT_TWO(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("assertion failed");

`endif

// File: sv/alunzcv_pkg.sv
// ----------------------------------------------------------------------------
// ALU package
// Widths, operation and condition codes, and the flag record.
// ----------------------------------------------------------------------------
package alunzcv_pkg;

    localparam int DATA_W  = 64;
    localparam int SHAMT_W = 6;
    localparam int KIND_W  = 4;
    localparam int COND_W  = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_ADD  = 4'd0,
        KIND_SUB  = 4'd1,
        KIND_ORN  = 4'd2,
        KIND_ORR  = 4'd3,
        KIND_EOR  = 4'd4,
        KIND_AND  = 4'd5,
        KIND_MOV  = 4'd6,
        KIND_LSL  = 4'd7,
        KIND_LSR  = 4'd8,
        KIND_ASR  = 4'd9,
        KIND_PASS = 4'd10
    } kind_t;

    typedef enum logic [COND_W-1:0] {
        COND_EQ = 4'd0,
        COND_NE = 4'd1,
        COND_CS = 4'd2,
        COND_CC = 4'd3,
        COND_MI = 4'd4,
        COND_PL = 4'd5,
        COND_VS = 4'd6,
        COND_VC = 4'd7,
        COND_HI = 4'd8,
        COND_LS = 4'd9,
        COND_GE = 4'd10,
        COND_LT = 4'd11,
        COND_GT = 4'd12,
        COND_LE = 4'd13,
        COND_AL = 4'd14
    } cond_t;

    // Packed so that n lands in bit 3 and v in bit 0.
    typedef struct packed {
        logic n;
        logic z;
        logic c;
        logic v;
    } flags_t;

endpackage

// File: sv/alu_with_nzcv_flags.sv
// ----------------------------------------------------------------------------
// 64-bit ALU with NZCV flags
// Stages: input register, then result register; a stalled output holds
//   the beat in the result register.
// Throughput: 1 beat per cycle unless the output stalls; flags are written
//   as a beat leaves the input register, so the next beat sees them at once.
// Reset: asynchronous, active low; clears both valid bits and the flags.
// ----------------------------------------------------------------------------
module alu_with_nzcv_flags (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [alunzcv_pkg::KIND_W-1:0]  kind,
    input  logic [alunzcv_pkg::DATA_W-1:0]  operand_a,
    input  logic [alunzcv_pkg::DATA_W-1:0]  operand_b,
    input  logic [alunzcv_pkg::SHAMT_W-1:0] move_shift,
    input  logic                            update_flags,
    input  logic [alunzcv_pkg::COND_W-1:0]  condition,
    // output channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [alunzcv_pkg::DATA_W-1:0]  result,
    output logic                            condition_true,
    output logic [3:0]                      flags_out
);
    import alunzcv_pkg::*;

    // Input register stage.
    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [DATA_W-1:0]    a_reg;
    logic [DATA_W-1:0]    b_reg;
    logic [SHAMT_W-1:0]   mshift_reg;
    logic                 setf_reg;
    logic [COND_W-1:0]    cond_reg;

    // Result register stage.
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [DATA_W-1:0]    result_reg;
    logic                 cond_true_reg;
    flags_t               flags_out_reg;

    // Architectural flag register.
    flags_t               flag_reg;
    flags_t               flag_next;

    // Execute results for the beat in the input register.
    logic [DATA_W-1:0]    exec_result;
    flags_t               exec_flags;
    logic                 exec_cond;

    logic                 out_take;   // result register can load this cycle
    logic                 s1_move;    // beat moves input reg -> result reg
    logic                 in_take;    // input beat accepted

    assign out_take = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_take;
    // Stall only when the input register holds a beat that cannot move on.
    assign in_stall = s1_valid_reg && !out_take;
    assign in_take  = in_valid && !in_stall;

    alunzcv_exec u_exec (
        .kind           (kind_reg),
        .operand_a      (a_reg),
        .operand_b      (b_reg),
        .move_shift     (mshift_reg),
        .update_flags   (setf_reg),
        .condition      (cond_reg),
        .flags_cur      (flag_reg),
        .result         (exec_result),
        .flags_new      (exec_flags),
        .condition_true (exec_cond)
    );

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        out_valid_next = out_valid_reg;
        flag_next      = flag_reg;
        if (s1_move)
        begin
            s1_valid_next = 1'b0;
            flag_next     = exec_flags;
        end
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        if (out_take)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flag_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            flag_reg      <= flag_next;
        end
    end

    // Payload registers: loaded on the handshake only, no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= kind;
            a_reg      <= operand_a;
            b_reg      <= operand_b;
            mshift_reg <= move_shift;
            setf_reg   <= update_flags;
            cond_reg   <= condition;
        end
        if (s1_move)
        begin
            result_reg    <= exec_result;
            cond_true_reg <= exec_cond;
            flags_out_reg <= exec_flags;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result         = result_reg;
    assign condition_true = cond_true_reg;
    assign flags_out      = flags_out_reg;

endmodule

// File: sv/alunzcv_exec.sv
// ----------------------------------------------------------------------------
// ALU execute logic
// Result, next NZCV flags and condition test for one beat.
// ----------------------------------------------------------------------------
module alunzcv_exec (
    input  logic [alunzcv_pkg::KIND_W-1:0]  kind,
    input  logic [alunzcv_pkg::DATA_W-1:0]  operand_a,
    input  logic [alunzcv_pkg::DATA_W-1:0]  operand_b,
    input  logic [alunzcv_pkg::SHAMT_W-1:0] move_shift,
    input  logic                            update_flags,
    input  logic [alunzcv_pkg::COND_W-1:0]  condition,
    input  alunzcv_pkg::flags_t             flags_cur,
    output logic [alunzcv_pkg::DATA_W-1:0]  result,
    output alunzcv_pkg::flags_t             flags_new,
    output logic                            condition_true
);
    import alunzcv_pkg::*;

    logic                 is_sub;
    logic [DATA_W-1:0]    b_op;
    logic [DATA_W:0]      sum;
    logic [DATA_W-1:0]    sum_lo;
    logic                 add_c;
    logic                 add_v;
    logic [SHAMT_W-1:0]   amt;
    logic signed [DATA_W-1:0] a_s;
    logic                 res_n;
    logic                 res_z;

    // One adder for add and subtract: a + ~b + 1, carry out = no borrow.
    assign is_sub = (kind == KIND_SUB);
    assign b_op   = is_sub ? ~operand_b : operand_b;
    assign sum    = {1'b0, operand_a} + {1'b0, b_op} + {{DATA_W{1'b0}}, is_sub};
    assign sum_lo = sum[DATA_W-1:0];
    assign add_c  = sum[DATA_W];
    assign add_v  = (operand_a[DATA_W-1] == b_op[DATA_W-1])
                 && (sum_lo[DATA_W-1] != operand_a[DATA_W-1]);

    assign amt = operand_b[SHAMT_W-1:0];
    assign a_s = $signed(operand_a);

    always_comb
    begin
        case (kind)
            KIND_ADD:  result = sum_lo;
            KIND_SUB:  result = sum_lo;
            KIND_ORN:  result = operand_a | ~operand_b;
            KIND_ORR:  result = operand_a | operand_b;
            KIND_EOR:  result = operand_a ^ operand_b;
            KIND_AND:  result = operand_a & operand_b;
            KIND_MOV:  result = operand_a | (operand_b << move_shift);
            KIND_LSL:  result = operand_a << amt;
            KIND_LSR:  result = operand_a >> amt;
            KIND_ASR:  result = DATA_W'(a_s >>> amt);
            KIND_PASS: result = operand_a;
            default:   result = '0;
        endcase
    end

    assign res_n = result[DATA_W-1];
    assign res_z = (result == '0);

    always_comb
    begin
        flags_new = flags_cur;
        if (update_flags)
        begin
            case (kind)
                KIND_ADD,
                KIND_SUB:  flags_new = '{n: res_n, z: res_z, c: add_c, v: add_v};
                KIND_AND,
                KIND_PASS: flags_new = '{n: res_n, z: res_z, c: flags_cur.c,
                                         v: flags_cur.v};
                default:   flags_new = flags_cur;
            endcase
        end
    end

    // Condition looks at the flags after this beat's update.
    always_comb
    begin
        case (condition)
            COND_EQ: condition_true = flags_new.z;
            COND_NE: condition_true = !flags_new.z;
            COND_CS: condition_true = flags_new.c;
            COND_CC: condition_true = !flags_new.c;
            COND_MI: condition_true = flags_new.n;
            COND_PL: condition_true = !flags_new.n;
            COND_VS: condition_true = flags_new.v;
            COND_VC: condition_true = !flags_new.v;
            COND_HI: condition_true = flags_new.c && !flags_new.z;
            COND_LS: condition_true = !(flags_new.c && !flags_new.z);
            COND_GE: condition_true = (flags_new.n == flags_new.v);
            COND_LT: condition_true = (flags_new.n != flags_new.v);
            COND_GT: condition_true = !flags_new.z && (flags_new.n == flags_new.v);
            COND_LE: condition_true = flags_new.z || (flags_new.n != flags_new.v);
            COND_AL: condition_true = 1'b1;
            default: condition_true = 1'b1;
        endcase
    end

endmodule

// File: sv/alunzcv_checker.sv
// ----------------------------------------------------------------------------
// ALU port checker
// Watches the top-level ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alunzcv_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [alunzcv_pkg::KIND_W-1:0]  kind,
    input  logic [alunzcv_pkg::DATA_W-1:0]  operand_a,
    input  logic [alunzcv_pkg::DATA_W-1:0]  operand_b,
    input  logic [alunzcv_pkg::SHAMT_W-1:0] move_shift,
    input  logic                            update_flags,
    input  logic [alunzcv_pkg::COND_W-1:0]  condition,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [alunzcv_pkg::DATA_W-1:0]  result,
    input  logic                            condition_true,
    input  logic [3:0]                      flags_out
);
    import alunzcv_pkg::*;

    logic in_beat;
    logic out_hold;

    assign in_beat  = in_valid && !in_stall;
    assign out_hold = out_valid && out_stall;

    // Input backs up only when the result beat is itself held.
    `ASSERT_IMPLY(a_stall_needs_full, clk, rst_n, in_stall, out_hold)

    // An accepted beat is followed by a valid output, checked by ASSERT_TWO.
    `ASSERT_TWO(a_beat_reaches_out, clk, rst_n, in_beat, out_valid)

    // A held result beat stays valid.
    `ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_hold, out_valid)

    // A held result beat keeps its payload.
    `ASSERT_NEXT(a_out_payload_holds, clk, rst_n, out_hold,
        $stable(result) && $stable(condition_true) && $stable(flags_out))

endmodule

bind alu_with_nzcv_flags alunzcv_checker u_checker (.*);
